// ===== hw/rtl/three_voice_psg_tone_noise_envelope_defines.svh =====
// Assertion macros shared by the sound generator RTL
`ifndef THREE_VOICE_PSG_TONE_NOISE_ENVELOPE_DEFINES_SVH
`define THREE_VOICE_PSG_TONE_NOISE_ENVELOPE_DEFINES_SVH
`ifndef NO_ASSERTIONS
// check on every clock edge outside reset
`define PSG_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// check on every clock edge, reset included
`define PSG_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PSG_ASSERT(label, prop, msg)
`define PSG_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

// ===== hw/rtl/tvpsg_pkg.sv =====
// Shared types, register map and helper functions of the sound generator
package tvpsg_pkg;

	localparam int NUM_REGISTERS = 16;
	localparam int REG_ADDR_W    = $clog2(NUM_REGISTERS);
	localparam int NUM_VOICES    = 3;
	localparam int LEVEL_W       = 5;
	localparam int TONE_W        = 12;
	localparam int NOISE_CNT_W   = 6;
	localparam int LFSR_W        = 17;
	localparam int ENV_CNT_W     = 16;

	// register map
	localparam logic [REG_ADDR_W-1:0] REG_TONE_A_COARSE = 4'd1;
	localparam logic [REG_ADDR_W-1:0] REG_TONE_B_COARSE = 4'd3;
	localparam logic [REG_ADDR_W-1:0] REG_TONE_C_COARSE = 4'd5;
	localparam logic [REG_ADDR_W-1:0] REG_NOISE_PERIOD  = 4'd6;
	localparam logic [REG_ADDR_W-1:0] REG_MIXER         = 4'd7;
	localparam logic [REG_ADDR_W-1:0] REG_AMP_A         = 4'd8;
	localparam logic [REG_ADDR_W-1:0] REG_AMP_B         = 4'd9;
	localparam logic [REG_ADDR_W-1:0] REG_AMP_C         = 4'd10;
	localparam logic [REG_ADDR_W-1:0] REG_ENV_FINE      = 4'd11;
	localparam logic [REG_ADDR_W-1:0] REG_ENV_COARSE    = 4'd12;
	localparam logic [REG_ADDR_W-1:0] REG_ENV_SHAPE     = 4'd13;

	// envelope shapes with special behavior at the range ends
	localparam logic [3:0] SHAPE_SAW_DOWN      = 4'd8;
	localparam logic [3:0] SHAPE_TRI_DOWN      = 4'd10;
	localparam logic [3:0] SHAPE_DOWN_HOLD_TOP = 4'd11;
	localparam logic [3:0] SHAPE_SAW_UP        = 4'd12;
	localparam logic [3:0] SHAPE_UP_HOLD_TOP   = 4'd13;
	localparam logic [3:0] SHAPE_TRI_UP        = 4'd14;

	localparam logic [7:0] READ_UNMAPPED = 8'hFF;
	localparam logic [LEVEL_W-1:0] LEVEL_MAX = 5'd31;

	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_READ  = 2'd1,
		OP_TICK  = 2'd2
	} op_t;

	typedef logic [NUM_REGISTERS-1:0][7:0] regfile_t;

	// one command from the input stage, valid for one cycle when fire is set
	typedef struct packed {
		logic                  fire;
		op_t                   op;
		logic                  addr_ok;
		logic [REG_ADDR_W-1:0] addr;
		logic [7:0]            value;
	} cmd_t;

	// generator outputs seen by the mixer
	typedef struct packed {
		logic [NUM_VOICES-1:0] tone_bits;
		logic                  noise_bit;
		logic [LEVEL_W-1:0]    env_level;
	} gen_view_t;

	typedef logic [NUM_VOICES-1:0][LEVEL_W-1:0] levels_t;

	// bits a register keeps on write
	function automatic logic [7:0] write_mask(input logic [REG_ADDR_W-1:0] a);
		logic [7:0] m;
		case (a) inside
			REG_TONE_A_COARSE, REG_TONE_B_COARSE, REG_TONE_C_COARSE, REG_ENV_SHAPE:
				m = 8'h0F;
			REG_NOISE_PERIOD, REG_AMP_A, REG_AMP_B, REG_AMP_C:
				m = 8'h1F;
			default:
				m = 8'hFF;
		endcase
		return m;
	endfunction

endpackage

// ===== hw/rtl/three_voice_psg_tone_noise_envelope.sv =====
// Top level of the three-voice sound generator core with stream ports
// Three-voice programmable sound generator. Each transfer on the s_ side is
// one command (tuser): a register write, a register read or one chip tick;
// every command gives exactly one transfer on the m_ side carrying the three
// 5-bit channel levels after the command and, for a read, the register byte
// (0xFF for an unmapped address, 0 for any other command). The core takes one
// command per cycle while the m_ side does not stall: the command is held in
// an input stage, then the register file, tone, noise and envelope state all
// update in the same cycle that the result register captures the mixed levels. The
// input stage keeps accepting while a result waits, as long as the result
// register is free or drained in the same cycle. cfg_wen/cfg_wdata set the
// address folding mode (1 folds addresses to 4 bits); write it only when idle.
`include "three_voice_psg_tone_noise_envelope_defines.svh"
module three_voice_psg_tone_noise_envelope (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic        cfg_wdata,    // chip_is_ay
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,      // [7:0] address, [15:8] value
	input  logic [1:0]  s_tuser,      // [1:0] op
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata       // [4:0] level_a, [9:5] level_b, [14:10] level_c,
	                                  // [22:15] read_data, [23] zero
);
	import tvpsg_pkg::*;

	logic chip_is_ay_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chip_is_ay_q <= 1'b0;
		end else if (cfg_wen) begin
			chip_is_ay_q <= cfg_wdata;
		end
	end

	// input stage
	logic       valid_s1;
	op_t        op_s1;
	logic [7:0] addr_s1;
	logic [7:0] value_s1;
	logic       advance;
	logic       s_fire;

	// advance the held command when the result register is free or drains now
	assign advance  = valid_s1 && (!m_tvalid || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign s_fire   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_fire) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			op_s1    <= op_t'(s_tuser);
			addr_s1  <= s_tdata[7:0];
			value_s1 <= s_tdata[15:8];
		end
	end

	// fold the address in 4-bit mode, otherwise only 0..15 are mapped
	cmd_t cmd;

	assign cmd.fire    = advance;
	assign cmd.op      = op_s1;
	assign cmd.addr_ok = chip_is_ay_q || (addr_s1[7:REG_ADDR_W] == '0);
	assign cmd.addr    = addr_s1[REG_ADDR_W-1:0];
	assign cmd.value   = value_s1;

	regfile_t   regs_q;
	regfile_t   regs_nx;
	logic [7:0] read_data;
	gen_view_t  view_nx;
	levels_t    levels;

	tvpsg_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.regs_q    (regs_q),
		.regs_nx   (regs_nx),
		.read_data (read_data)
	);

	// a tick only reads the registers, so the current file drives it
	tvpsg_gen u_gen (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.regs    (regs_q),
		.view_nx (view_nx)
	);

	// levels reflect the state after this command
	tvpsg_mix u_mix (
		.regs   (regs_nx),
		.view   (view_nx),
		.levels (levels)
	);

	// result register
	logic        out_valid_q;
	logic [23:0] out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= {1'b0, read_data, levels[2], levels[1], levels[0]};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	`PSG_ASSERT(a_result_follows, advance |=> m_tvalid, "command advanced without a result")
	`PSG_ASSERT(a_stall_keeps_cmd, (valid_s1 && !advance) |=> valid_s1, "held command was lost")
	`PSG_ASSERT(a_read_data_only_on_read, (advance && (op_s1 != OP_READ)) |=> (m_tdata[22:15] == 8'd0), "read data on a non-read result")
	`PSG_ASSERT_ALWAYS(a_reset_empty, (!arst_n) |=> (!m_tvalid && !valid_s1), "pipeline not empty after reset")

endmodule

// ===== hw/rtl/tvpsg_regs.sv =====
// Register file: masked writes and register reads
module tvpsg_regs (
	input  logic                clk,
	input  logic                arst_n,
	input  tvpsg_pkg::cmd_t     cmd,
	output tvpsg_pkg::regfile_t regs_q,
	output tvpsg_pkg::regfile_t regs_nx,
	output logic [7:0]          read_data
);
	import tvpsg_pkg::*;

	always_comb begin
		regs_nx = regs_q;
		if (cmd.fire && cmd.op == OP_WRITE && cmd.addr_ok) begin
			regs_nx[cmd.addr] = cmd.value & write_mask(cmd.addr);
		end
	end

	// reads never change state, so the current contents answer
	always_comb begin
		read_data = 8'd0;
		if (cmd.op == OP_READ) begin
			read_data = cmd.addr_ok ? regs_q[cmd.addr] : READ_UNMAPPED;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= '0;
		end else begin
			regs_q <= regs_nx;
		end
	end

endmodule

// ===== hw/rtl/tvpsg_gen.sv =====
// Tone, noise and envelope generators advanced one chip tick at a time
module tvpsg_gen (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tvpsg_pkg::cmd_t      cmd,
	input  tvpsg_pkg::regfile_t  regs,
	output tvpsg_pkg::gen_view_t view_nx
);
	import tvpsg_pkg::*;

	logic tick;
	logic restart;

	assign tick    = cmd.fire && cmd.op == OP_TICK;
	assign restart = cmd.fire && cmd.op == OP_WRITE && cmd.addr_ok && cmd.addr == REG_ENV_SHAPE;

	// tone voices
	logic [NUM_VOICES-1:0][TONE_W-1:0] tone_cnt_q, tone_cnt_nx;
	logic [NUM_VOICES-1:0]             tone_bit_q, tone_bit_nx;

	for (genvar ch = 0; ch < NUM_VOICES; ch++) begin : g_tone
		logic [TONE_W-1:0] period;
		logic [TONE_W:0]   inc;
		logic              hit;

		assign period = {regs[2*ch+1][3:0], regs[2*ch]};
		assign inc    = {1'b0, tone_cnt_q[ch]} + 1'b1;
		assign hit    = inc >= {1'b0, period};

		always_comb begin
			tone_cnt_nx[ch] = tone_cnt_q[ch];
			tone_bit_nx[ch] = tone_bit_q[ch];
			if (tick) begin
				tone_cnt_nx[ch] = hit ? '0 : inc[TONE_W-1:0];
				tone_bit_nx[ch] = tone_bit_q[ch] ^ hit;
			end
		end
	end

	// noise divider and shift register
	logic [NOISE_CNT_W-1:0] noise_cnt_q, noise_cnt_nx;
	logic [LFSR_W-1:0]      lfsr_q, lfsr_nx;
	logic [NOISE_CNT_W-1:0] noise_period;
	logic [NOISE_CNT_W:0]   noise_inc;
	logic                   noise_hit;
	logic                   feedback;

	assign noise_period = {regs[REG_NOISE_PERIOD][4:0], 1'b0};
	assign noise_inc    = {1'b0, noise_cnt_q} + 1'b1;
	assign noise_hit    = noise_inc >= {1'b0, noise_period};
	assign feedback     = lfsr_q[16] ^ lfsr_q[13];

	always_comb begin
		noise_cnt_nx = noise_cnt_q;
		lfsr_nx      = lfsr_q;
		if (tick) begin
			noise_cnt_nx = noise_hit ? '0 : noise_inc[NOISE_CNT_W-1:0];
			if (noise_hit) begin
				lfsr_nx = {lfsr_q[LFSR_W-2:0], 1'b1} ^ {{(LFSR_W-1){1'b0}}, feedback};
			end
		end
	end

	// envelope
	logic [ENV_CNT_W-1:0] env_cnt_q, env_cnt_nx;
	logic [LEVEL_W-1:0]   env_level_q, env_level_nx;
	logic signed [1:0]    env_step_q, env_step_nx;
	logic [ENV_CNT_W-1:0] env_period;
	logic [ENV_CNT_W:0]   env_inc;
	logic                 env_hit;
	logic [LEVEL_W+1:0]   env_sum;
	logic                 env_under;
	logic                 env_over;
	logic                 attack;

	assign env_period = {regs[REG_ENV_COARSE], regs[REG_ENV_FINE]};
	assign env_inc    = {1'b0, env_cnt_q} + 1'b1;
	assign env_hit    = env_inc >= {1'b0, env_period};
	assign env_sum    = {2'b00, env_level_q} + {{LEVEL_W{env_step_q[1]}}, env_step_q};
	assign env_under  = env_sum[LEVEL_W+1];
	assign env_over   = env_sum == {2'b01, {LEVEL_W{1'b0}}};
	assign attack     = cmd.value[2];

	always_comb begin
		env_cnt_nx   = env_cnt_q;
		env_level_nx = env_level_q;
		env_step_nx  = env_step_q;
		if (restart) begin
			env_cnt_nx   = '0;
			env_level_nx = attack ? '0 : LEVEL_MAX;
			env_step_nx  = attack ? 2'sd1 : -2'sd1;
		end else if (tick) begin
			env_cnt_nx = env_hit ? '0 : env_inc[ENV_CNT_W-1:0];
			if (env_hit) begin
				if (!env_under && !env_over) begin
					env_level_nx = env_sum[LEVEL_W-1:0];
				end else begin
					case (regs[REG_ENV_SHAPE][3:0]) inside
						SHAPE_SAW_DOWN, SHAPE_SAW_UP: begin
							env_level_nx = env_sum[LEVEL_W-1:0];
						end
						SHAPE_TRI_DOWN, SHAPE_TRI_UP: begin
							// turn around: the level stays where it was
							env_step_nx = -env_step_q;
						end
						SHAPE_DOWN_HOLD_TOP, SHAPE_UP_HOLD_TOP: begin
							env_level_nx = LEVEL_MAX;
							env_step_nx  = 2'sd0;
						end
						default: begin
							env_level_nx = '0;
							env_step_nx  = 2'sd0;
						end
					endcase
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tone_cnt_q  <= '0;
			tone_bit_q  <= '0;
			noise_cnt_q <= '0;
			lfsr_q      <= 17'h0FFFF;
			env_cnt_q   <= '0;
			env_level_q <= LEVEL_MAX;
			env_step_q  <= -2'sd1;
		end else begin
			tone_cnt_q  <= tone_cnt_nx;
			tone_bit_q  <= tone_bit_nx;
			noise_cnt_q <= noise_cnt_nx;
			lfsr_q      <= lfsr_nx;
			env_cnt_q   <= env_cnt_nx;
			env_level_q <= env_level_nx;
			env_step_q  <= env_step_nx;
		end
	end

	assign view_nx.tone_bits = tone_bit_nx;
	assign view_nx.noise_bit = lfsr_nx[LFSR_W-1];
	assign view_nx.env_level = env_level_nx;

endmodule

// ===== hw/rtl/tvpsg_mix.sv =====
// Per-channel mixer: amplitude or envelope gated by tone and noise
module tvpsg_mix (
	input  tvpsg_pkg::regfile_t  regs,
	input  tvpsg_pkg::gen_view_t view,
	output tvpsg_pkg::levels_t   levels
);
	import tvpsg_pkg::*;

	for (genvar ch = 0; ch < NUM_VOICES; ch++) begin : g_chan
		logic [7:0]         amp;
		logic [LEVEL_W-1:0] src;
		logic               tone_ok;
		logic               noise_ok;

		assign amp      = regs[REG_AMP_A + ch];
		assign src      = amp[4] ? view.env_level : {amp[3:0], 1'b1};
		assign tone_ok  = view.tone_bits[ch] | regs[REG_MIXER][ch];
		assign noise_ok = view.noise_bit | regs[REG_MIXER][ch+NUM_VOICES];
		assign levels[ch] = (tone_ok && noise_ok) ? src : '0;
	end

endmodule

// ===== tb/three_voice_psg_tone_noise_envelope_test.sv =====
// Stream-level self-checking testbench for the three-voice sound generator core
module three_voice_psg_tone_noise_envelope_test;
	import tvpsg_pkg::*;

	// run limit in clock cycles, far above the slowest legal run
	localparam int CYCLE_LIMIT = 1000000;
	// cycles to let pass after the last result before touching the mode bit or ending
	localparam int SETTLE_CYCLES = 8;
	localparam int MAX_REPORTS = 10;

	// command code with no function: the block must ignore it
	localparam logic [1:0] OP_UNUSED = 2'd3;

	// register indexes the package leaves unnamed
	localparam logic [3:0] REG_TONE_A_FINE   = 4'd0;
	localparam logic [3:0] REG_PORT_B        = 4'd15;

	// layout of one m_tdata word, lowest field last
	typedef struct packed {
		logic       pad;
		logic [7:0] read_data;
		logic [4:0] level_c;
		logic [4:0] level_b;
		logic [4:0] level_a;
	} psg_result_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cfg_wen   = 1'b0;
	logic        cfg_wdata = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata   = '0;    // [7:0] address, [15:8] value
	logic [1:0]  s_tuser   = '0;    // [1:0] op
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [23:0] m_tdata;           // [4:0] level_a, [9:5] level_b, [14:10] level_c,
	                                // [22:15] read_data, [23] zero

	three_voice_psg_tone_noise_envelope u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	// ------------------------------------------------------------------
	// Predicted chip state, kept in step with every accepted command
	// ------------------------------------------------------------------
	logic [7:0]             mdl_regs [NUM_REGISTERS];
	logic [TONE_W-1:0]      mdl_tone_cnt [NUM_VOICES];
	logic [NUM_VOICES-1:0]  mdl_tone_bit;
	logic [NOISE_CNT_W-1:0] mdl_noise_cnt;
	logic [LFSR_W-1:0]      mdl_lfsr;
	logic [ENV_CNT_W-1:0]   mdl_env_cnt;
	int                     mdl_env_level;
	int                     mdl_env_step;
	logic                   mdl_fold;

	// levels expected on the master side, oldest first
	psg_result_t levels_due [$];

	int   cycle_count     = 0;
	int   mismatches      = 0;
	int   results_checked = 0;
	int   cmds_sent       = 0;
	int   shapes_run      = 0;
	logic idle_on         = 1'b1;

	psg_result_t chk_want;
	psg_result_t chk_got;

	// Apply one command to the predicted state and return the levels it reports.
	function automatic psg_result_t psg_predict(input logic [1:0] op,
		input logic [7:0] addr_in, input logic [7:0] val_in);
		psg_result_t r;
		logic [7:0]  addr;
		logic [7:0]  val;
		logic [7:0]  amp;
		logic [4:0]  src;
		logic [4:0]  lvl [NUM_VOICES];
		logic [3:0]  shape;
		int unsigned period;
		int unsigned nxt;

		r = '0;
		// in folding mode only the low nibble selects the register
		addr = mdl_fold ? {4'd0, addr_in[3:0]} : addr_in;
		case (op)
			OP_WRITE: begin
				if (addr < NUM_REGISTERS) begin
					case (addr[3:0])
						REG_TONE_A_COARSE, REG_TONE_B_COARSE, REG_TONE_C_COARSE,
						REG_ENV_SHAPE: val = val_in & 8'h0F;
						REG_NOISE_PERIOD, REG_AMP_A, REG_AMP_B, REG_AMP_C:
							val = val_in & 8'h1F;
						default: val = val_in;
					endcase
					mdl_regs[addr[3:0]] = val;
					// any shape write restarts the envelope from its start point
					if (addr[3:0] == REG_ENV_SHAPE) begin
						mdl_env_cnt = '0;
						if (val[2]) begin
							mdl_env_level = 0;
							mdl_env_step  = 1;
						end else begin
							mdl_env_level = 31;
							mdl_env_step  = -1;
						end
					end
				end
			end
			OP_READ: begin
				r.read_data = (addr < NUM_REGISTERS) ? mdl_regs[addr[3:0]] : READ_UNMAPPED;
			end
			OP_TICK: begin
				// tone dividers: clear and toggle once the period is reached or passed
				for (int v = 0; v < NUM_VOICES; v++) begin
					period = {mdl_regs[2*v+1][3:0], mdl_regs[2*v]};
					nxt    = mdl_tone_cnt[v] + 1;
					if (nxt >= period) begin
						mdl_tone_cnt[v] = '0;
						mdl_tone_bit[v] = ~mdl_tone_bit[v];
					end else begin
						mdl_tone_cnt[v] = TONE_W'(nxt);
					end
				end
				// noise divider runs at twice the register value, then shifts the LFSR
				period = {mdl_regs[REG_NOISE_PERIOD][4:0], 1'b0};
				nxt    = mdl_noise_cnt + 1;
				if (nxt >= period) begin
					mdl_noise_cnt = '0;
					mdl_lfsr = {mdl_lfsr[15:0], 1'b1 ^ mdl_lfsr[16] ^ mdl_lfsr[13]};
				end else begin
					mdl_noise_cnt = NOISE_CNT_W'(nxt);
				end
				// envelope divider, then step the level and apply the shape at the ends
				period = {mdl_regs[REG_ENV_COARSE], mdl_regs[REG_ENV_FINE]};
				nxt    = mdl_env_cnt + 1;
				if (nxt >= period) begin
					mdl_env_cnt   = '0;
					mdl_env_level = mdl_env_level + mdl_env_step;
					if (mdl_env_level < 0 || mdl_env_level > 31) begin
						shape = mdl_regs[REG_ENV_SHAPE][3:0];
						case (shape)
							SHAPE_SAW_DOWN, SHAPE_SAW_UP: mdl_env_level = mdl_env_level & 31;
							SHAPE_TRI_DOWN, SHAPE_TRI_UP: begin
								mdl_env_step  = -mdl_env_step;
								mdl_env_level = mdl_env_level + mdl_env_step;
							end
							SHAPE_DOWN_HOLD_TOP, SHAPE_UP_HOLD_TOP: begin
								mdl_env_level = 31;
								mdl_env_step  = 0;
							end
							default: begin
								mdl_env_level = 0;
								mdl_env_step  = 0;
							end
						endcase
					end
				end else begin
					mdl_env_cnt = ENV_CNT_W'(nxt);
				end
			end
			default: ;
		endcase

		// mix: a disabled source reads as passing, the amplitude picks the source level
		for (int v = 0; v < NUM_VOICES; v++) begin
			amp = mdl_regs[REG_AMP_A + v];
			src = amp[4] ? 5'(mdl_env_level) : {amp[3:0], 1'b1};
			if ((mdl_tone_bit[v] | mdl_regs[REG_MIXER][v]) &
			    (mdl_lfsr[16] | mdl_regs[REG_MIXER][v+3]))
				lvl[v] = src;
			else
				lvl[v] = '0;
		end
		r.level_a = lvl[0];
		r.level_b = lvl[1];
		r.level_c = lvl[2];
		return r;
	endfunction

	// Idle length for either side: mostly none or short, now and then long.
	function automatic int pick_gap();
		int r;
		if (!idle_on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Address for a register; in folding mode the upper nibble is random junk.
	function automatic logic [7:0] alias_of(input logic [3:0] r);
		return mdl_fold ? {4'($urandom), r} : {4'd0, r};
	endfunction

	// ------------------------------------------------------------------
	// Slave side: present one command and hold it until it transfers
	// ------------------------------------------------------------------
	task automatic send_cmd(input logic [1:0] op, input logic [7:0] addr,
		input logic [7:0] val);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {val, addr};
		// ready is stable mid-cycle; the transfer happens at the following edge
		do @(negedge clk); while (!s_tready);
		@(posedge clk);
		levels_due.push_back(psg_predict(op, addr, val));
		cmds_sent++;
	endtask

	// Drop valid and hold off until every expected result has come back.
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (levels_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write the address folding mode; only done with the core idle.
	task automatic set_fold(input logic ay);
		wait_idle();
		cfg_wen   <= 1'b1;
		cfg_wdata <= ay;
		@(posedge clk);
		cfg_wen  <= 1'b0;
		mdl_fold = ay;
		@(posedge clk);
	endtask

	task automatic note_mismatch(input string what, input psg_result_t want,
		input psg_result_t got);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("%s at cycle %0d: want a=%0d b=%0d c=%0d rd=%02h z=%0b, got a=%0d b=%0d c=%0d rd=%02h z=%0b",
				what, cycle_count, want.level_a, want.level_b, want.level_c,
				want.read_data, want.pad, got.level_a, got.level_b, got.level_c,
				got.read_data, got.pad);
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Reset contents, unmapped addresses, write masks, every command code,
	// shape restart and a tone period lowered below its running count.
	task automatic test_directed();
		set_fold(1'b0);
		send_cmd(OP_READ, 8'h00, 8'h00);
		send_cmd(OP_READ, 8'hFF, 8'hFF);
		send_cmd(OP_WRITE, 8'hFF, 8'hFF);
		send_cmd(OP_WRITE, 8'h10, 8'hA5);
		send_cmd(OP_READ, 8'h10, 8'h5A);
		send_cmd(OP_WRITE, alias_of(REG_TONE_A_COARSE), 8'hFF);
		send_cmd(OP_READ, alias_of(REG_TONE_A_COARSE), 8'h00);
		send_cmd(OP_WRITE, alias_of(REG_TONE_A_FINE), 8'hFF);
		send_cmd(OP_WRITE, alias_of(REG_NOISE_PERIOD), 8'hFF);
		send_cmd(OP_WRITE, alias_of(REG_AMP_A), 8'hFF);
		send_cmd(OP_WRITE, alias_of(REG_AMP_B), 8'h0F);
		send_cmd(OP_WRITE, alias_of(REG_PORT_B), 8'hFF);
		send_cmd(OP_READ, alias_of(REG_PORT_B), 8'h00);
		send_cmd(OP_WRITE, alias_of(REG_ENV_SHAPE), {4'hF, SHAPE_TRI_UP});
		repeat (3) send_cmd(OP_TICK, 8'h00, 8'h00);
		send_cmd(OP_UNUSED, 8'hFF, 8'hFF);
		// same shape again still restarts the envelope
		send_cmd(OP_WRITE, alias_of(REG_ENV_SHAPE), {4'hF, SHAPE_TRI_UP});
		send_cmd(OP_TICK, 8'h00, 8'h00);
		// drop the tone A period below the running count
		send_cmd(OP_WRITE, alias_of(REG_TONE_A_COARSE), 8'h00);
		send_cmd(OP_WRITE, alias_of(REG_TONE_A_FINE), 8'h02);
		send_cmd(OP_TICK, 8'h00, 8'h00);
		send_cmd(OP_READ, alias_of(REG_ENV_SHAPE), 8'h00);
		send_cmd(OP_WRITE, alias_of(REG_MIXER), 8'hFF);
		send_cmd(OP_TICK, 8'h00, 8'h00);
	endtask

	// Walk every envelope shape through both range ends with a short period,
	// random tone, noise, mixer and amplitude setup around it.
	task automatic test_envelope_shapes();
		int ticks;
		int voice;
		set_fold(1'b1);
		for (int shape = 0; shape < 16; shape++) begin
			// every fourth shape runs with both sides at full rate
			idle_on = (shape % 4) != 0;
			voice = $urandom_range(0, NUM_VOICES - 1);
			send_cmd(OP_WRITE, alias_of(4'(2 * voice)), 8'($urandom_range(0, 9)));
			// coarse bits above the mask are random, the kept nibble stays zero
			send_cmd(OP_WRITE, alias_of(4'(2 * voice + 1)), {4'($urandom), 4'h0});
			send_cmd(OP_WRITE, alias_of(REG_NOISE_PERIOD), 8'($urandom));
			send_cmd(OP_WRITE, alias_of(REG_MIXER),
				($urandom_range(0, 2) == 0) ? 8'($urandom) : {2'($urandom), 6'h3F});
			send_cmd(OP_WRITE, alias_of(REG_AMP_A), {3'($urandom), 1'b1, 4'($urandom)});
			send_cmd(OP_WRITE, alias_of(4'($urandom_range(REG_AMP_B, REG_AMP_C))),
				8'($urandom));
			send_cmd(OP_WRITE, alias_of(REG_ENV_FINE), 8'($urandom_range(0, 1)));
			send_cmd(OP_WRITE, alias_of(REG_ENV_COARSE), 8'h00);
			send_cmd(OP_WRITE, alias_of(REG_ENV_SHAPE), {4'($urandom), 4'(shape)});
			// 32 steps carry the level past either end
			ticks = $urandom_range(32, 34);
			repeat (ticks) begin
				if ($urandom_range(0, 15) == 0)
					send_cmd(OP_READ, alias_of(4'($urandom)), 8'($urandom));
				send_cmd(OP_TICK, 8'($urandom), 8'($urandom));
			end
			shapes_run++;
		end
		idle_on = 1'b1;
	endtask

	// Mixed traffic over the whole address and value range in both modes.
	task automatic test_random_traffic();
		int r;
		logic [7:0] addr;
		for (int phase = 0; phase < 4; phase++) begin
			set_fold(phase[0]);
			idle_on = (phase != 2);
			for (int n = 0; n < 12; n++) begin
				// hold off once mid-phase until every result has drained
				if (phase == 1 && n == 6)
					wait_idle();
				r = $urandom_range(0, 19);
				addr = $urandom_range(0, 1) ? 8'($urandom) : 8'($urandom_range(0, 15));
				if (r < 10)
					send_cmd(OP_TICK, 8'($urandom), 8'($urandom));
				else if (r < 15)
					send_cmd(OP_WRITE, addr, 8'($urandom));
				else if (r < 18)
					send_cmd(OP_READ, addr, 8'($urandom));
				else
					send_cmd(OP_UNUSED, addr, 8'($urandom));
			end
		end
		idle_on = 1'b1;
		// leave the mode bit at its reset value at the end
		set_fold(1'b0);
	endtask

	// ------------------------------------------------------------------
	// Free-running processes
	// ------------------------------------------------------------------
	initial begin
		forever #5 clk = ~clk;
	end

	// Stop a run that hangs.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("three_voice_psg_tone_noise_envelope test failed");
			$finish;
		end
	end

	// Master side pacing: stall for a random gap, then accept for a short run.
	initial begin : rx_pacing
		int stall;
		forever begin
			@(posedge clk);
			stall = pick_gap();
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			repeat ($urandom_range(0, 6)) @(posedge clk);
		end
	end

	// Compare each master transfer with the oldest expectation. Sample mid-cycle,
	// where valid, ready and data are settled for the coming edge.
	always @(negedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			chk_got = psg_result_t'(m_tdata);
			if (levels_due.size() == 0) begin
				note_mismatch("result with nothing pending", '0, chk_got);
			end else begin
				chk_want = levels_due.pop_front();
				results_checked++;
				if (chk_got.level_a !== chk_want.level_a ||
				    chk_got.level_b !== chk_want.level_b ||
				    chk_got.level_c !== chk_want.level_c ||
				    chk_got.read_data !== chk_want.read_data ||
				    chk_got.pad !== chk_want.pad)
					note_mismatch("level mismatch", chk_want, chk_got);
			end
		end
	end

	// ------------------------------------------------------------------
	// Sequence: reset, tests in turn, drain, verdict
	// ------------------------------------------------------------------
	initial begin
		for (int i = 0; i < NUM_REGISTERS; i++)
			mdl_regs[i] = '0;
		for (int v = 0; v < NUM_VOICES; v++)
			mdl_tone_cnt[v] = '0;
		mdl_tone_bit  = '0;
		mdl_noise_cnt = '0;
		mdl_lfsr      = 17'h0FFFF;
		mdl_env_cnt   = '0;
		mdl_env_level = 31;
		mdl_env_step  = -1;
		mdl_fold      = 1'b0;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_envelope_shapes();
		test_random_traffic();
		wait_idle();

		$display("Sent %0d commands and checked %0d results; %0d envelope shapes walked,",
			cmds_sent, results_checked, shapes_run);
		$display("writes, reads, ticks and the unused code run in both address modes.");
		if (mismatches == 0) begin
			$display("three_voice_psg_tone_noise_envelope test passed");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("three_voice_psg_tone_noise_envelope test failed");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/tvpsg_pkg.sv
hw/rtl/tvpsg_regs.sv
hw/rtl/tvpsg_gen.sv
hw/rtl/tvpsg_mix.sv
hw/rtl/three_voice_psg_tone_noise_envelope.sv
tb/three_voice_psg_tone_noise_envelope_test.sv
